// File: rtl/hsl2rgb_pkg.sv
// Shared constants, sector codes and inter-stage payload types for the HSL to RGB converter.
package hsl2rgb_pkg;

  // Channel and intermediate widths
  localparam int unsigned CH_W   = 8;
  localparam int unsigned PROD_W = 16;  // a * s, up to 65025
  localparam int unsigned WGT_W  = 10;  // 2b - 255, signed -255..255
  localparam int unsigned NUM_W  = 25;  // secondary numerator, below 256 * DEN
  localparam int unsigned HQ_W   = 7;   // floor(a*s / 510), up to 127

  // Common denominator 2*255*255 and its half-scale factor 2*255
  localparam logic [NUM_W-1:0] DEN      = 25'd130050;
  localparam logic [16:0]      DEN_HALF = 17'd510;

  // Reciprocals: floor(2^32 / 130050) and floor(2^24 / 510)
  localparam logic [15:0] RECIP_DEN  = 16'd33025;
  localparam logic [15:0] RECIP_HALF = 16'd32896;

  // Hue sectors, one per sixth of the colour circle
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // After the product stage
  typedef struct packed {
    logic [CH_W-1:0]         lightness;
    logic [PROD_W-1:0]       prod;
    logic signed [WGT_W-1:0] weight;
    sector_t                 sector;
  } terms_t;

  // After the scaling stages
  typedef struct packed {
    logic [CH_W-1:0]  lightness;
    logic [NUM_W-1:0] num;
    logic [CH_W-1:0]  quo_est;
    logic [HQ_W-1:0]  half_q;
    logic             half_nz;
    sector_t          sector;
  } scaled_t;

endpackage

// File: rtl/hsl2rgb_terms.sv
// Stages 1 and 2: lightness and hue terms, sector decode, then the a * s product.
module hsl2rgb_terms (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [7:0]            hue,
  input  logic [7:0]            saturation,
  input  logic [7:0]            lightness,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsl2rgb_pkg::terms_t   out_data
);
  import hsl2rgb_pkg::*;

  // Stage 1 registers
  logic                  s1_valid;
  logic [CH_W-1:0]       s1_light;
  logic [CH_W-1:0]       s1_sat;
  logic [CH_W-1:0]       s1_a;
  logic signed [WGT_W-1:0] s1_weight;
  sector_t               s1_sector;

  logic s1_ready;
  logic s2_ready;

  // Stage 1 logic
  logic [8:0]  light_dbl;
  logic [7:0]  light_dev;
  logic [7:0]  a_term;
  logic [10:0] hue_x6;
  logic [8:0]  hue_mod;
  logic [7:0]  hue_dev;
  logic signed [WGT_W-1:0] weight;
  sector_t     sector;

  // a = 255 - |2l - 255|
  always_comb begin
    light_dbl = {lightness, 1'b0};
    if (light_dbl >= 9'd255) begin
      light_dev = 8'(light_dbl - 9'd255);
    end else begin
      light_dev = 8'(9'd255 - light_dbl);
    end
    a_term = 8'd255 - light_dev;
  end

  // weight = 2b - 255 with b = 255 - |(6h mod 510) - 255|
  always_comb begin
    hue_x6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};
    if (hue_x6 >= 11'd1020) begin
      hue_mod = 9'(hue_x6 - 11'd1020);
    end else if (hue_x6 >= 11'd510) begin
      hue_mod = 9'(hue_x6 - 11'd510);
    end else begin
      hue_mod = 9'(hue_x6);
    end
    if (hue_mod >= 9'd255) begin
      hue_dev = 8'(hue_mod - 9'd255);
    end else begin
      hue_dev = 8'(9'd255 - hue_mod);
    end
    weight = $signed(10'd255) - $signed({1'b0, hue_dev, 1'b0});
  end

  // Sector = floor(6h / 255), full-scale hue folded into the last sector
  always_comb begin
    if (hue >= 8'd213) begin
      sector = SEC_MAG_RED;
    end else if (hue >= 8'd170) begin
      sector = SEC_BLU_MAG;
    end else if (hue >= 8'd128) begin
      sector = SEC_CYN_BLU;
    end else if (hue >= 8'd85) begin
      sector = SEC_GRN_CYN;
    end else if (hue >= 8'd43) begin
      sector = SEC_YEL_GRN;
    end else begin
      sector = SEC_RED_YEL;
    end
  end

  // Stage handshake: a stage loads when empty or when its content moves on
  assign s2_ready = !out_valid || out_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign in_ready = s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_light  <= lightness;
      s1_sat    <= saturation;
      s1_a      <= a_term;
      s1_weight <= weight;
      s1_sector <= sector;
    end
  end

  // Stage 2: the a * s product
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_ready && s1_valid) begin
      out_data.lightness <= s1_light;
      out_data.prod      <= PROD_W'(s1_a) * PROD_W'(s1_sat);
      out_data.weight    <= s1_weight;
      out_data.sector    <= s1_sector;
    end
  end

endmodule

// File: rtl/hsl2rgb_scale.sv
// Stages 3 and 4: secondary numerator, reciprocal quotient estimates and the divide-by-510 fix-up.
module hsl2rgb_scale (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsl2rgb_pkg::terms_t   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hsl2rgb_pkg::scaled_t  out_data
);
  import hsl2rgb_pkg::*;

  // Stage 3 registers
  logic              s3_valid;
  logic [CH_W-1:0]   s3_light;
  logic [PROD_W-1:0] s3_prod;
  logic [NUM_W-1:0]  s3_num;
  logic [HQ_W-1:0]   s3_half_est;
  sector_t           s3_sector;

  logic s3_ready;
  logic s4_ready;

  // Stage 3 logic
  logic signed [16:0] prod_s;
  logic signed [26:0] mix;
  logic [NUM_W-1:0]   base;
  logic [NUM_W-1:0]   num;
  logic [31:0]        half_prod;

  // num = 2*as*b - 255*as + l*D = as*(2b-255) + l*D, always in 0..255*D
  always_comb begin
    prod_s    = $signed({1'b0, in_data.prod});
    mix       = 27'(prod_s) * 27'(in_data.weight);
    base      = NUM_W'(in_data.lightness) * DEN;
    num       = NUM_W'(mix) + base;
    half_prod = 32'(in_data.prod) * 32'(RECIP_HALF);
  end

  assign s4_ready = !out_valid || out_ready;
  assign s3_ready = !s3_valid || s4_ready;
  assign in_ready = s3_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s3_ready) begin
      s3_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_ready && in_valid) begin
      s3_light    <= in_data.lightness;
      s3_prod     <= in_data.prod;
      s3_num      <= num;
      s3_half_est <= half_prod[30:24];
      s3_sector   <= in_data.sector;
    end
  end

  // Stage 4 logic: quotient estimate for num / D, exact as / 510
  logic [40:0]     num_prod;
  logic [16:0]     half_rem;
  logic [16:0]     half_rem_fix;
  logic [HQ_W-1:0] half_q;

  always_comb begin
    num_prod = 41'(s3_num) * 41'(RECIP_DEN);
    half_rem = 17'(s3_prod) - 17'(s3_half_est) * DEN_HALF;
    if (half_rem >= DEN_HALF) begin
      half_q       = s3_half_est + HQ_W'(1);
      half_rem_fix = half_rem - DEN_HALF;
    end else begin
      half_q       = s3_half_est;
      half_rem_fix = half_rem;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s4_ready) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s4_ready && s3_valid) begin
      out_data.lightness <= s3_light;
      out_data.num       <= s3_num;
      out_data.quo_est   <= num_prod[39:32];
      out_data.half_q    <= half_q;
      out_data.half_nz   <= (half_rem_fix != 17'd0);
      out_data.sector    <= s3_sector;
    end
  end

endmodule

// File: rtl/hsl2rgb_route.sv
// Stage 5: final quotient correction, channel values and sector routing into the output register.
module hsl2rgb_route (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hsl2rgb_pkg::scaled_t  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            red,
  output logic [7:0]            green,
  output logic [7:0]            blue
);
  import hsl2rgb_pkg::*;

  logic [NUM_W-1:0] sec_rem;
  logic [CH_W-1:0]  sec_val;
  logic [CH_W-1:0]  chroma_val;
  logic [CH_W-1:0]  floor_val;
  logic [CH_W-1:0]  red_next;
  logic [CH_W-1:0]  green_next;
  logic [CH_W-1:0]  blue_next;

  // Channel values: secondary = num / D, chroma = l + as/510, zero = l - ceil(as/510)
  always_comb begin
    sec_rem = in_data.num - NUM_W'(in_data.quo_est) * DEN;
    if (sec_rem >= DEN) begin
      sec_val = in_data.quo_est + CH_W'(1);
    end else begin
      sec_val = in_data.quo_est;
    end
    chroma_val = in_data.lightness + CH_W'(in_data.half_q);
    floor_val  = in_data.lightness - CH_W'(in_data.half_q) - CH_W'(in_data.half_nz);
  end

  // Route per hue sector
  always_comb begin
    unique case (in_data.sector)
      SEC_RED_YEL: begin
        red_next = chroma_val; green_next = sec_val;    blue_next = floor_val;
      end
      SEC_YEL_GRN: begin
        red_next = sec_val;    green_next = chroma_val; blue_next = floor_val;
      end
      SEC_GRN_CYN: begin
        red_next = floor_val;  green_next = chroma_val; blue_next = sec_val;
      end
      SEC_CYN_BLU: begin
        red_next = floor_val;  green_next = sec_val;    blue_next = chroma_val;
      end
      SEC_BLU_MAG: begin
        red_next = sec_val;    green_next = floor_val;  blue_next = chroma_val;
      end
      default: begin
        red_next = chroma_val; green_next = floor_val;  blue_next = sec_val;
      end
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      red   <= red_next;
      green <= green_next;
      blue  <= blue_next;
    end
  end

endmodule

// File: rtl/hsl_to_rgb_converter.sv
// Top level of the HSL to RGB converter: stream ports and the five-stage pipeline.
//
//   Channel   Dir  Handshake          Payload
//   s_axis    in   s_tvalid/s_tready  s_tdata: hue, saturation, lightness
//   m_axis    out  m_tvalid/m_tready  m_tdata: red, green, blue
//
// One transfer in per clock when the output side keeps up; five register stages, so the
// result is registered in stages 1 to 5 in turn before it is valid on m_tdata.
// Stage 1 folds hue and lightness and decodes the sector; stages 2 to 5 hold the multiplies
// (a*s; as*weight and as*reciprocal; num*reciprocal and estimate*510; quotient*D), none iterates.
// Reset clears the stage valid bits only; data registers are not reset.
// A stall on m_tready holds the output; empty stages upstream still fill.
module hsl_to_rgb_converter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // hue [7:0], saturation [15:8], lightness [23:16]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata    // red [7:0], green [15:8], blue [23:16]
);
  import hsl2rgb_pkg::*;

  logic    terms_valid;
  logic    terms_ready;
  terms_t  terms;
  logic    scaled_valid;
  logic    scaled_ready;
  scaled_t scaled;
  logic [CH_W-1:0] red;
  logic [CH_W-1:0] green;
  logic [CH_W-1:0] blue;

  // Stages 1-2
  hsl2rgb_terms u_terms (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .hue        (s_tdata[7:0]),
    .saturation (s_tdata[15:8]),
    .lightness  (s_tdata[23:16]),
    .out_valid  (terms_valid),
    .out_ready  (terms_ready),
    .out_data   (terms)
  );

  // Stages 3-4
  hsl2rgb_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (terms_valid),
    .in_ready  (terms_ready),
    .in_data   (terms),
    .out_valid (scaled_valid),
    .out_ready (scaled_ready),
    .out_data  (scaled)
  );

  // Stage 5 and output register
  hsl2rgb_route u_route (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (scaled_valid),
    .in_ready  (scaled_ready),
    .in_data   (scaled),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .red       (red),
    .green     (green),
    .blue      (blue)
  );

  assign m_tdata = {blue, green, red};

endmodule

// File: tb/tb_top.sv
// Self-checking testbench for the HSL to RGB converter: exact integer predictor, stream traffic.
`timescale 1ns / 100ps

module tb_top;
  import hsl2rgb_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;  // cycles with no transfer on either side
  localparam int unsigned DRAIN_CYCLES = 20;   // five-stage pipeline plus margin
  localparam logic [31:0] FULL = 32'd255;
  localparam logic [31:0] DENOM = 32'd130050;  // 2 * 255 * 255

  typedef struct packed {
    logic [7:0] lightness;
    logic [7:0] saturation;
    logic [7:0] hue;
  } hsl_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  rgb_t        pending_rgb[$];
  int unsigned error_count = 0;
  int unsigned quiet_cycles = 0;
  int unsigned sink_hold = 0;
  bit          src_idle = 1'b0;
  bit          snk_idle = 1'b0;

  hsl_to_rgb_converter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // hue [7:0], saturation [15:8], lightness [23:16]
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)    // red [7:0], green [15:8], blue [23:16]
  );

  always #5 clk = ~clk;

  // Exact conversion over the common denominator, one truncation per channel
  function automatic rgb_t predict_rgb(hsl_t c);
    logic [31:0] h, s, l, light_span, hue_ramp, hue_fold, span_sat;
    logic [31:0] chroma_num, second_num, offset_num, r_num, g_num, b_num;
    logic [31:0] sect_raw;
    sector_t     sect;
    rgb_t        res;
    h = {24'd0, c.hue};
    s = {24'd0, c.saturation};
    l = {24'd0, c.lightness};
    light_span = FULL - ((2 * l >= FULL) ? (2 * l - FULL) : (FULL - 2 * l));
    hue_fold   = (6 * h) % (2 * FULL);
    hue_ramp   = FULL - ((hue_fold >= FULL) ? (hue_fold - FULL) : (FULL - hue_fold));
    span_sat   = light_span * s;
    chroma_num = span_sat * 2 * FULL;
    second_num = 2 * span_sat * hue_ramp;
    offset_num = l * DENOM - span_sat * FULL;
    // hue at full scale lands in a seventh sector; fold it into the last one
    sect_raw = (6 * h) / FULL;
    sect = (sect_raw > 32'd5) ? SEC_MAG_RED : sector_t'(sect_raw[2:0]);
    case (sect)
      SEC_RED_YEL: begin r_num = chroma_num; g_num = second_num; b_num = 0; end
      SEC_YEL_GRN: begin r_num = second_num; g_num = chroma_num; b_num = 0; end
      SEC_GRN_CYN: begin r_num = 0; g_num = chroma_num; b_num = second_num; end
      SEC_CYN_BLU: begin r_num = 0; g_num = second_num; b_num = chroma_num; end
      SEC_BLU_MAG: begin r_num = second_num; g_num = 0; b_num = chroma_num; end
      default:     begin r_num = chroma_num; g_num = 0; b_num = second_num; end
    endcase
    res.red   = 8'((r_num + offset_num) / DENOM);
    res.green = 8'((g_num + offset_num) / DENOM);
    res.blue  = 8'((b_num + offset_num) / DENOM);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] want,
                                 input logic [7:0] got);
    $display("MISMATCH %s: expected %0d, got %0d at %0t", what, want, got, $time);
    error_count++;
  endtask

  // One colour in; valid is only lowered when a gap is drawn
  task automatic send_colour(input logic [7:0] h, input logic [7:0] s, input logic [7:0] l);
    int unsigned gap;
    hsl_t        c;
    gap = src_idle ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    c.hue = h;
    c.saturation = s;
    c.lightness = l;
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_rgb.push_back(predict_rgb(c));
  endtask

  function automatic logic [7:0] pick_field();
    logic [7:0] corner[4];
    corner = '{8'd0, 8'd255, 8'd127, 8'd128};
    if ($urandom_range(0, 7) == 0) return corner[$urandom_range(0, 3)];
    return 8'($urandom);
  endfunction

  task automatic send_random(input int unsigned count);
    repeat (count) send_colour(pick_field(), pick_field(), pick_field());
  endtask

  // Sector edges at full saturation and mid lightness, incl. hue at full scale
  task automatic test_hue_sectors();
    logic [7:0] edges[13];
    edges = '{8'd0, 8'd42, 8'd43, 8'd85, 8'd86, 8'd127, 8'd128,
              8'd170, 8'd171, 8'd212, 8'd213, 8'd254, 8'd255};
    src_idle = 1'b0;
    snk_idle = 1'b0;
    foreach (edges[i]) send_colour(edges[i], 8'd255, 8'd128);
  endtask

  // Black, white, greys and the lightness fold points
  task automatic test_extremes();
    send_colour(8'd0, 8'd0, 8'd0);
    send_colour(8'd255, 8'd255, 8'd255);
    send_colour(8'd255, 8'd255, 8'd0);
    send_colour(8'd0, 8'd255, 8'd255);
    send_colour(8'd100, 8'd0, 8'd200);
    send_colour(8'd30, 8'd255, 8'd127);
    send_colour(8'd30, 8'd255, 8'd128);
    send_colour(8'd200, 8'd1, 8'd128);
    send_colour(8'd64, 8'd254, 8'd1);
    send_colour(8'd150, 8'd128, 8'd254);
  endtask

  task automatic test_back_to_back();
    src_idle = 1'b0;
    snk_idle = 1'b0;
    send_random(400);
  endtask

  task automatic test_both_idle();
    src_idle = 1'b1;
    snk_idle = 1'b1;
    send_random(800);
  endtask

  task automatic test_one_side_idle();
    src_idle = 1'b1;
    snk_idle = 1'b0;
    send_random(200);
    src_idle = 1'b0;
    snk_idle = 1'b1;
    send_random(200);
  endtask

  // Result sink: compare each transfer, then draw a stall before the next one
  always @(posedge clk) begin
    rgb_t want, got;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      got = m_tdata;
      if (pending_rgb.size() == 0) begin
        $display("UNEXPECTED result %h at %0t", m_tdata, $time);
        error_count++;
      end else begin
        want = pending_rgb.pop_front();
        if (got.red !== want.red) report_mismatch("red", want.red, got.red);
        if (got.green !== want.green) report_mismatch("green", want.green, got.green);
        if (got.blue !== want.blue) report_mismatch("blue", want.blue, got.blue);
      end
      sink_hold = snk_idle ? $urandom_range(0, 15) : 0;
      if (sink_hold != 0) m_tready <= 1'b0;
    end else if (!m_tready) begin
      // ready returns once sink_hold has counted down
      if (sink_hold <= 1) begin
        sink_hold = 0;
        m_tready <= 1'b1;
      end else begin
        sink_hold--;
      end
    end
  end

  // Watchdog on cycles with no transfer at all
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_hue_sectors();
    test_extremes();
    test_back_to_back();
    test_both_idle();
    test_one_side_idle();
    s_tvalid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
